// ===== design/stq_pkg.sv =====
// Shared types and constants for the sorted timer queue.
package stq_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int MAX_EXPIRE      = 16;
  localparam int EXP_CNT_W       = $clog2(MAX_EXPIRE);

  localparam logic [1:0] ACT_INSTALL = 2'd0;
  localparam logic [1:0] ACT_KILL    = 2'd1;
  localparam logic [1:0] ACT_TICK    = 2'd2;
  localparam logic [1:0] ACT_UNUSED  = 2'd3;

  localparam logic [2:0] KIND_INSTALLED = 3'd0;
  localparam logic [2:0] KIND_FULL      = 3'd1;
  localparam logic [2:0] KIND_KILLED    = 3'd2;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [2:0] KIND_EXPIRED   = 3'd4;
  localparam logic [2:0] KIND_NONE      = 3'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] delay_ms;
    logic [31:0] elapsed_ms;
    logic [15:0] target_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] tid;
    logic        last;
  } res_t;

  typedef struct packed {
    logic load;
    logic insert;
    logic remove;
    logic report_kill;
    logic subtract;
    logic pop;
    logic pop_last;
    logic report_none;
  } cmd_t;

  typedef struct packed {
    logic any_match;
    logic head_zero;
    logic next_zero;
  } sts_t;

endpackage

// ===== design/sorted_timer_queue_core.sv =====
// Top level of the sorted timer queue: controller plus timer table datapath.
// A request is taken when start is high and busy is low; results come out one
// per cycle on strobe and cannot be held off. Install makes one table update
// and then reports, kill removes matching entries one at a time and then
// reports, and tick does the parallel subtract and then pops the expired
// ids as results (at most 16 expired ids, or one none item).
// Timing is set by the controller walking the table one shift per cycle; busy
// drops as the last result is registered, so a new request may be accepted
// in the cycle its predecessor's final strobe is shown. Unused action code 3
// is taken and ignored.
module sorted_timer_queue_core #(
  parameter int TIMER_SLOTS = stq_pkg::TIMER_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  stq_pkg::req_t req,
  output logic          strobe,
  output stq_pkg::res_t result
);

  stq_pkg::cmd_t cmd;
  stq_pkg::sts_t sts;

  stq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (req.action),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  stq_datapath #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .sts    (sts),
    .strobe (strobe),
    .result (result)
  );

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result strobe without a request in progress");

endmodule

// ===== design/stq_ctrl.sv =====
// Sequencing state machine for the sorted timer queue.
module stq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    action,
  input  stq_pkg::sts_t sts,
  output stq_pkg::cmd_t cmd,
  output logic          busy
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_INSTALL = 5'b00010,
    S_KILL    = 5'b00100,
    S_SUB     = 5'b01000,
    S_POP     = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [stq_pkg::EXP_CNT_W-1:0] cnt, cnt_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (action)
            stq_pkg::ACT_INSTALL: begin
              cmd.load   = 1'b1;
              state_next = S_INSTALL;
            end
            stq_pkg::ACT_KILL: begin
              cmd.load   = 1'b1;
              state_next = S_KILL;
            end
            stq_pkg::ACT_TICK: begin
              cmd.load   = 1'b1;
              state_next = S_SUB;
            end
            default: ;
          endcase
        end
      end
      S_INSTALL: begin
        cmd.insert = 1'b1;
        state_next = S_IDLE;
      end
      S_KILL: begin
        if (sts.any_match) begin
          cmd.remove = 1'b1;
        end else begin
          cmd.report_kill = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_SUB: begin
        cmd.subtract = 1'b1;
        cnt_next     = '0;
        state_next   = S_POP;
      end
      S_POP: begin
        if (sts.head_zero) begin
          cmd.pop      = 1'b1;
          cmd.pop_last = !sts.next_zero ||
                         (cnt == stq_pkg::EXP_CNT_W'(stq_pkg::MAX_EXPIRE - 1));
          cnt_next     = cnt + 1'b1;
          if (cmd.pop_last) begin
            state_next = S_IDLE;
          end
        end else begin
          cmd.report_none = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign busy = (state != S_IDLE);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action != stq_pkg::ACT_UNUSED) |=> busy)
    else $error("accepted request did not raise busy");

  a_none_first: assert property (@(posedge clk) disable iff (rst)
    cmd.report_none |-> $past(state == S_SUB))
    else $error("none-expired reported after a pop");

endmodule

// ===== design/stq_datapath.sv =====
// Sorted timer table cells, request latch and result register.
module stq_datapath #(
  parameter int TIMER_SLOTS = stq_pkg::TIMER_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  stq_pkg::req_t req,
  input  stq_pkg::cmd_t cmd,
  output stq_pkg::sts_t sts,
  output logic          strobe,
  output stq_pkg::res_t result
);

  localparam int LVL = $clog2(TIMER_SLOTS);

  stq_pkg::req_t                  req_q;
  logic [TIMER_SLOTS-1:0][31:0]   rem, rem_next;
  logic [TIMER_SLOTS-1:0][15:0]   ident, ident_next;
  logic [TIMER_SLOTS-1:0]         used, used_next;
  logic [TIMER_SLOTS-1:0]         ge, match, pre;
  logic [LVL:0][TIMER_SLOTS-1:0]  scan;
  logic [15:0]                    next_ident;
  logic                           hit;
  logic                           full;

  assign full = used[TIMER_SLOTS-1];

  always_comb begin
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      ge[i]    = !used[i] || (rem[i] >= req_q.delay_ms);
      match[i] = used[i] && (ident[i] == req_q.target_id);
    end
  end

  // parallel prefix OR: pre[i] set when a match sits at or below i
  always_comb begin
    scan[0] = match;
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        if (i >= (1 << l)) begin
          scan[l+1][i] = scan[l][i] | scan[l][i - (1 << l)];
        end else begin
          scan[l+1][i] = scan[l][i];
        end
      end
    end
    pre = scan[LVL];
  end

  always_comb begin
    rem_next   = rem;
    ident_next = ident;
    used_next  = used;
    if (cmd.insert && !full) begin
      if (ge[0]) begin
        rem_next[0]   = req_q.delay_ms;
        ident_next[0] = next_ident;
      end
      for (int i = 1; i < TIMER_SLOTS; i++) begin
        if (ge[i-1]) begin
          rem_next[i]   = rem[i-1];
          ident_next[i] = ident[i-1];
        end else if (ge[i]) begin
          rem_next[i]   = req_q.delay_ms;
          ident_next[i] = next_ident;
        end
      end
      used_next = {used[TIMER_SLOTS-2:0], 1'b1};
    end else if (cmd.remove) begin
      for (int i = 0; i < TIMER_SLOTS - 1; i++) begin
        if (pre[i]) begin
          rem_next[i]   = rem[i+1];
          ident_next[i] = ident[i+1];
          used_next[i]  = used[i+1];
        end
      end
      if (pre[TIMER_SLOTS-1]) begin
        used_next[TIMER_SLOTS-1] = 1'b0;
      end
    end else if (cmd.subtract) begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        rem_next[i] = (rem[i] > req_q.elapsed_ms) ? rem[i] - req_q.elapsed_ms : '0;
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < TIMER_SLOTS - 1; i++) begin
        rem_next[i]   = rem[i+1];
        ident_next[i] = ident[i+1];
      end
      used_next = {1'b0, used[TIMER_SLOTS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    rem   <= rem_next;
    ident <= ident_next;
    if (cmd.load) begin
      req_q <= req;
    end
    if (rst) begin
      used       <= '0;
      next_ident <= '0;
      hit        <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      used   <= used_next;
      strobe <= cmd.insert | cmd.report_kill | cmd.pop | cmd.report_none;
      if (cmd.load) begin
        hit <= 1'b0;
      end else if (cmd.remove) begin
        hit <= 1'b1;
      end
      if (cmd.insert) begin
        result.last <= 1'b1;
        if (full) begin
          result.kind <= stq_pkg::KIND_FULL;
          result.tid  <= '0;
        end else begin
          result.kind <= stq_pkg::KIND_INSTALLED;
          result.tid  <= next_ident;
          next_ident  <= next_ident + 1'b1;
        end
      end
      if (cmd.report_kill) begin
        result.kind <= hit ? stq_pkg::KIND_KILLED : stq_pkg::KIND_NOT_FOUND;
        result.tid  <= req_q.target_id;
        result.last <= 1'b1;
      end
      if (cmd.pop) begin
        result.kind <= stq_pkg::KIND_EXPIRED;
        result.tid  <= ident[0];
        result.last <= cmd.pop_last;
      end
      if (cmd.report_none) begin
        result.kind <= stq_pkg::KIND_NONE;
        result.tid  <= '0;
        result.last <= 1'b1;
      end
    end
  end

  assign sts.any_match = |match;
  assign sts.head_zero = used[0] && (rem[0] == '0);
  assign sts.next_zero = used[1] && (rem[1] == '0);

  a_used_prefix: assert property (@(posedge clk) disable iff (rst)
    ((used + 1'b1) & used) == '0)
    else $error("occupied slots are not a prefix");

  for (genvar g = 0; g < TIMER_SLOTS - 1; g++) begin : g_order
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      used[g+1] |-> (rem[g] <= rem[g+1]))
      else $error("timer table out of order");
  end

endmodule
